@@ rtl/efd_pkg.sv @@
// Shared types, constants and arithmetic helpers of the error-diffusion dither.
package efd_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	localparam int DIM_W     = 11;
	localparam int THR_W     = 8;
	localparam int PIX_W     = 8;
	localparam int NCH       = 3;
	localparam int FIX_W     = 14;
	localparam int WORD_W    = NCH * FIX_W;
	localparam int CFG_IDX_W = 2;

	// compare width for position versus size, with room for position + 1
	localparam int POS_W = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int CMP_W = ((POS_W + 1 > DIM_W) ? POS_W + 1 : DIM_W) + 1;

	localparam int E_W   = 16;
	localparam int SUM_W = 20;

	localparam int FIX_LOW  = -4096;
	localparam int FIX_HIGH = 8191;
	localparam int FULL_ON  = 4080;

	localparam logic [2:0] WT_RIGHT      = 3'd7;
	localparam logic [2:0] WT_BELOW_LEFT = 3'd3;
	localparam logic [2:0] WT_BELOW      = 3'd5;
	localparam logic [2:0] WT_BELOW_RGT  = 3'd1;

	localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(1024);
	localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(1024);
	localparam logic [THR_W-1:0] THR_RST    = THR_W'(128);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH     = 2'd0,
		REG_HEIGHT    = 2'd1,
		REG_THRESHOLD = 2'd2
	} cfg_reg_t;

	typedef logic signed [FIX_W-1:0] fix_t;

	typedef struct packed {
		logic [COL_W-1:0] x;
		logic             last_col;
		logic             last_row;
		logic             row_nz;
		logic             fwd_hit;
	} s1_ctl_t;

	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] addr;
		logic [WORD_W-1:0] data;
	} ram_wr_t;

	function automatic fix_t sat_fix(input logic signed [SUM_W-1:0] v);
		fix_t r;
		if (v < FIX_LOW) begin
			r = FIX_W'(FIX_LOW);
		end else if (v > FIX_HIGH) begin
			r = FIX_W'(FIX_HIGH);
		end else begin
			r = FIX_W'(v);
		end
		return r;
	endfunction

	// weighted share w/16 of an error, rounded to nearest with ties upward
	function automatic fix_t share(input logic signed [E_W-1:0] e, input logic [2:0] w);
		logic signed [SUM_W-1:0] p;
		p = SUM_W'(e) * signed'(SUM_W'(w)) + SUM_W'(8);
		return sat_fix(p >>> 4);
	endfunction

endpackage

@@ rtl/efd_if.sv @@
// Stream and configuration channel interfaces of the error-diffusion dither.
interface efd_px_if;
	import efd_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_in;
	logic [PIX_W-1:0] green_in;
	logic [PIX_W-1:0] blue_in;
	modport source (output valid, red_in, green_in, blue_in, input ready);
	modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface efd_bit_if;
	logic valid;
	logic ready;
	logic red_on;
	logic green_on;
	logic blue_on;
	logic row_end;
	logic frame_end;
	modport source (output valid, red_on, green_on, blue_on, row_end, frame_end, input ready);
	modport sink (input valid, red_on, green_on, blue_on, row_end, frame_end, output ready);
endinterface

interface efd_cfg_if;
	import efd_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/efd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module efd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/efd_diffuse.sv @@
// Threshold and error-spreading datapath with the row-buffer write port.
module efd_diffuse (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     adv,
	input  efd_pkg::s1_ctl_t                         ctl,
	input  logic [efd_pkg::NCH-1:0][efd_pkg::PIX_W-1:0] pix,
	input  logic [efd_pkg::WORD_W-1:0]               rd_data,
	input  logic [efd_pkg::WORD_W-1:0]               fwd_data,
	input  logic [efd_pkg::THR_W-1:0]                thr,
	output logic [efd_pkg::NCH-1:0]                  on,
	output efd_pkg::ram_wr_t                         wr
);

	import efd_pkg::*;

	fix_t carry_q [NCH];
	fix_t blp_q   [NCH];
	fix_t bp_q    [NCH];

	fix_t                    row_err [NCH];
	logic signed [SUM_W-1:0] v_sum   [NCH];
	fix_t                    v       [NCH];
	logic signed [E_W-1:0]   e       [NCH];
	fix_t                    s7      [NCH];
	fix_t                    s3      [NCH];
	fix_t                    s5      [NCH];
	fix_t                    s1      [NCH];
	fix_t                    blp_n   [NCH];
	logic [WORD_W-1:0]       left_word;
	logic [WORD_W-1:0]       here_word;

	logic                    pend_valid_q;
	logic [COL_W-1:0]        pend_addr_q;
	logic [WORD_W-1:0]       pend_data_q;
	logic                    wr_left;
	logic                    wr_here;
	logic                    pend_set;

	always_comb begin
		left_word = '0;
		here_word = '0;
		for (int c = 0; c < NCH; c++) begin
			row_err[c] = ctl.fwd_hit ? fix_t'(fwd_data[c*FIX_W +: FIX_W])
			                         : fix_t'(rd_data[c*FIX_W +: FIX_W]);
			v_sum[c] = signed'(SUM_W'({pix[c], 4'b0000})) + SUM_W'(carry_q[c])
			         + (ctl.row_nz ? SUM_W'(row_err[c]) : SUM_W'(0));
			v[c]  = sat_fix(v_sum[c]);
			on[c] = E_W'(v[c]) >= signed'(E_W'({1'b0, thr, 4'b0000}));
			e[c]  = on[c] ? E_W'(v[c]) - E_W'(FULL_ON) : E_W'(v[c]);
			s7[c] = share(e[c], WT_RIGHT);
			s3[c] = share(e[c], WT_BELOW_LEFT);
			s5[c] = share(e[c], WT_BELOW);
			s1[c] = share(e[c], WT_BELOW_RGT);
			blp_n[c] = sat_fix(SUM_W'(bp_q[c]) + SUM_W'(s5[c]));
			left_word[c*FIX_W +: FIX_W] = sat_fix(SUM_W'(blp_q[c]) + SUM_W'(s3[c]));
			here_word[c*FIX_W +: FIX_W] = blp_n[c];
		end
	end

	// one write port: the lower-left entry goes first, a row-end entry that
	// collides with it waits in the pending register and is written the next cycle
	always_comb begin
		wr_left  = adv && (ctl.x != '0);
		wr_here  = adv && ctl.last_col;
		pend_set = wr_left && wr_here;
		wr       = '0;
		if (wr_left) begin
			wr.en   = 1'b1;
			wr.addr = ctl.x - COL_W'(1);
			wr.data = left_word;
		end else if (wr_here) begin
			wr.en   = 1'b1;
			wr.addr = ctl.x;
			wr.data = here_word;
		end else if (pend_valid_q) begin
			wr.en   = 1'b1;
			wr.addr = pend_addr_q;
			wr.data = pend_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			for (int c = 0; c < NCH; c++) begin
				carry_q[c] <= '0;
				blp_q[c]   <= '0;
				bp_q[c]    <= '0;
			end
		end else begin
			if (pend_set) begin
				pend_valid_q <= 1'b1;
			end else if (!wr_left && !wr_here) begin
				pend_valid_q <= 1'b0;
			end
			if (adv) begin
				for (int c = 0; c < NCH; c++) begin
					carry_q[c] <= ctl.last_col ? fix_t'(0) : s7[c];
					blp_q[c]   <= ctl.last_col ? fix_t'(0) : blp_n[c];
					bp_q[c]    <= ctl.last_col ? fix_t'(0) : s1[c];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_set) begin
			pend_addr_q <= ctl.x;
			pend_data_q <= here_word;
		end
	end

	// a deferred row-end write drains on the very next cycle
	a_pend_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |=> !pend_valid_q)
		else $error("deferred row-buffer write not drained");

	// while a write is deferred only a row-start pixel can advance
	a_pend_row_start: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_valid_q && adv) |-> (ctl.x == '0))
		else $error("pixel with lower-left write met a deferred write");

endmodule

@@ rtl/error_diffusion_dither_core.sv @@
// Floyd-Steinberg error-diffusion dither core, RGB pixel stream to one bit per channel.
// Sustains one pixel per clock unless the output stalls; a pixel's result passes the
// row-buffer read stage, then threshold and error spread into the output register. The
// row buffer is one RAM of MAX_WIDTH words of three 14-bit error sums with a single
// write port; the end-of-row entry, which coincides with the lower-left write, is held
// in a pending register, and a same-cycle write to the entry being read is forwarded.
// The clock rate is set by the right-neighbor error loop: add, saturate, threshold
// compare and the 7/16 share, all in one combinational path. The first row of a frame
// ignores the buffer, so the RAM needs no clearing after reset. Configuration (width,
// height, threshold) must be written while the stream is idle, which the core does not
// enforce; sizes of zero act as one and sizes above the maximum act as the maximum.
module error_diffusion_dither_core (
	input  logic   clk,
	input  logic   arst_n,
	efd_px_if.sink   pix,
	efd_bit_if.source dith,
	efd_cfg_if.sink  cfg
);

	import efd_pkg::*;

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [THR_W-1:0] thr_q;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [CMP_W-1:0] w_ext;
	logic [CMP_W-1:0] h_ext;
	logic [CMP_W-1:0] w_eff;
	logic [CMP_W-1:0] h_eff;
	logic             last_col_a;
	logic             last_row_a;

	logic             acc;
	logic             s1_adv;
	logic             s1_valid_q;
	s1_ctl_t          ctl_s1;
	logic [NCH-1:0][PIX_W-1:0] pix_s1;
	logic [WORD_W-1:0] fwd_data_s1;

	logic [WORD_W-1:0] rd_data;
	ram_wr_t           wr;
	logic [NCH-1:0]    on;

	logic              out_valid_q;
	logic [NCH-1:0]    on_q;
	logic              row_end_q;
	logic              frame_end_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			thr_q    <= THR_RST;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_WIDTH:     width_q  <= cfg.data;
				REG_HEIGHT:    height_q <= cfg.data;
				REG_THRESHOLD: thr_q    <= cfg.data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w_ext = CMP_W'(width_q);
		h_ext = CMP_W'(height_q);
		if (w_ext == '0) begin
			w_eff = CMP_W'(1);
		end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
			w_eff = CMP_W'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		if (h_ext == '0) begin
			h_eff = CMP_W'(1);
		end else if (h_ext > CMP_W'(MAX_HEIGHT)) begin
			h_eff = CMP_W'(MAX_HEIGHT);
		end else begin
			h_eff = h_ext;
		end
		last_col_a = (CMP_W'(col_q) + CMP_W'(1)) >= w_eff;
		last_row_a = (CMP_W'(row_q) + CMP_W'(1)) >= h_eff;
	end

	assign s1_adv    = s1_valid_q && (!out_valid_q || dith.ready);
	assign pix.ready = !s1_valid_q || s1_adv;
	assign acc       = pix.valid && pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (acc) begin
				if (last_col_a) begin
					col_q <= '0;
					row_q <= last_row_a ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	// register the accepted pixel; capture a row-buffer write to the entry read this cycle
	always_ff @(posedge clk) begin
		if (acc) begin
			ctl_s1.x        <= col_q;
			ctl_s1.last_col <= last_col_a;
			ctl_s1.last_row <= last_row_a;
			ctl_s1.row_nz   <= (row_q != '0);
			ctl_s1.fwd_hit  <= wr.en && (wr.addr == col_q);
			fwd_data_s1     <= wr.data;
			pix_s1[0]       <= pix.red_in;
			pix_s1[1]       <= pix.green_in;
			pix_s1[2]       <= pix.blue_in;
		end
	end

	efd_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_WIDTH)
	) u_row_ram (
		.clk  (clk),
		.we   (wr.en),
		.waddr(wr.addr),
		.wdata(wr.data),
		.re   (acc),
		.raddr(col_q),
		.rdata(rd_data)
	);

	efd_diffuse u_diffuse (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (s1_adv),
		.ctl     (ctl_s1),
		.pix     (pix_s1),
		.rd_data (rd_data),
		.fwd_data(fwd_data_s1),
		.thr     (thr_q),
		.on      (on),
		.wr      (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (dith.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			on_q        <= on;
			row_end_q   <= ctl_s1.last_col;
			frame_end_q <= ctl_s1.last_col && ctl_s1.last_row;
		end
	end

	assign dith.valid     = out_valid_q;
	assign dith.red_on    = on_q[0];
	assign dith.green_on  = on_q[1];
	assign dith.blue_on   = on_q[2];
	assign dith.row_end   = row_end_q;
	assign dith.frame_end = frame_end_q;

	// a pixel leaving the buffer stage always lands in the output register
	a_adv_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_valid_q)
		else $error("advanced pixel lost before output register");

endmodule
